[sv/nns_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Nearest-neighbour scaler package
// Sizes, register indexes, shared types and configuration helpers.
// -----------------------------------------------------------------------------
package nns_pkg;

   localparam int MAX_DIM      = 256;
   localparam int MAX_CHANNELS = 4;

   localparam int SRC_REG_W  = 9;
   localparam int DST_W      = 13;
   localparam int CH_REG_W   = 3;
   localparam int COORD_W    = 12;
   localparam int PIX_W      = 32;
   localparam int WORD_BYTES = PIX_W / 8;
   localparam int MAX_BYTES  = (MAX_CHANNELS < WORD_BYTES) ? MAX_CHANNELS : WORD_BYTES;

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int Q_W     = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * Q_W;
   localparam int NUM_W   = COORD_W + DIM_W;
   localparam int AREA_W  = 2 * DIM_W;
   localparam int CNT_W   = $clog2(Q_W + 1);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = PIX_W + 2 * COORD_W;
   localparam int RSP_DATA_W = PIX_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH     = 3'd0,
      REG_SRC_HEIGHT    = 3'd1,
      REG_DST_WIDTH     = 3'd2,
      REG_DST_HEIGHT    = 3'd3,
      REG_CHANNEL_COUNT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DST_W-1:0] dst_width;
      logic [DST_W-1:0] dst_height;
      logic [PIX_W-1:0] pixel_mask;
   } cfg_type;

   typedef struct packed {
      logic             is_read;
      logic             out_of_range;
      logic [PIX_W-1:0] pixel;
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
   } cmd_type;

   function automatic logic [DIM_W-1:0] clamp_src(input logic [SRC_REG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [DST_W-1:0] clamp_dst(input logic [DST_W-1:0] v);
      return (v == '0) ? DST_W'(1) : v;
   endfunction

   function automatic logic [PIX_W-1:0] pixel_mask(input logic [CH_REG_W-1:0] n);
      int               cnt;
      logic [PIX_W-1:0] m;
      cnt = int'(n);
      if (cnt == 0) cnt = 1;
      if (cnt > MAX_BYTES) cnt = MAX_BYTES;
      for (int b = 0; b < WORD_BYTES; b++) begin
         m[8*b +: 8] = (b < cnt) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

[sv/nns_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Scaler front end
// Accept request transfers, check range and form the scaled numerators.
// -----------------------------------------------------------------------------
module nns_front import nns_pkg::*; (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_in, dst_col, dst_row
   input  logic                  req_tuser,   // operation
   input  cfg_type               cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_item
);

   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;

   assign col = req_tdata[PIX_W +: COORD_W];
   assign row = req_tdata[PIX_W + COORD_W +: COORD_W];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.is_read      = (req_tuser == OP_READ);
      q_item.out_of_range = (DST_W'(col) >= cfg.dst_width) || (DST_W'(row) >= cfg.dst_height);
      q_item.pixel        = req_tdata[PIX_W-1:0];
      q_item.num_x        = NUM_W'(col) * NUM_W'(cfg.src_width);
      q_item.num_y        = NUM_W'(row) * NUM_W'(cfg.src_height);
   end

endmodule

[sv/nns_queue.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Scaler command queue
// Short FIFO between front end and back end.
// -----------------------------------------------------------------------------
module nns_queue import nns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_item,
   output logic    full,
   output logic    valid,
   input  logic    pop,
   output cmd_type pop_item
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
   endfunction

   assign full     = (int'(count_ff) == QUEUE_DEPTH);
   assign valid    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/nns_back.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Scaler back end
// Write the frame store, divide the scaled coordinates, fetch and emit pixels.
// -----------------------------------------------------------------------------
module nns_back import nns_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  cmd_type               q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pixel_out
   output logic                  rsp_tuser    // out_of_range
);

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      INDEX,
      FETCH,
      EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [AREA_W-1:0]  area_ff;
   logic [NUM_W-1:0]   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [NUM_W-1:0]   div_x_ff, div_x_in, div_y_ff, div_y_in;
   logic [Q_W-1:0]     quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               oor_ff, oor_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic [PIX_W-1:0]   store [STORE_DEPTH];
   logic [PIX_W-1:0]   rd_data_ff;
   logic               store_we;
   logic [ADDR_W-1:0]  wr_pos;
   logic [AREA_W-1:0]  wr_next;
   logic               ge_x, ge_y;

   assign wr_pos  = (AREA_W'(pos_ff) >= area_ff) ? '0 : pos_ff;
   assign wr_next = AREA_W'(wr_pos) + AREA_W'(1);
   assign ge_x    = (rem_x_ff >= div_x_ff);
   assign ge_y    = (rem_y_ff >= div_y_ff);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      div_x_in     = div_x_ff;
      div_y_in     = div_y_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      cnt_in       = cnt_ff;
      oor_in       = oor_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_oor_in   = rsp_oor_ff;
      q_pop        = 1'b0;
      store_we     = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_item.is_read) begin
                  store_we = 1'b1;
                  pos_in   = (wr_next >= area_ff) ? '0 : ADDR_W'(wr_next);
               end else if (q_item.out_of_range) begin
                  oor_in   = 1'b1;
                  state_in = EMIT;
               end else begin
                  oor_in   = 1'b0;
                  rem_x_in = q_item.num_x;
                  rem_y_in = q_item.num_y;
                  div_x_in = NUM_W'(cfg.dst_width) << (Q_W - 1);
                  div_y_in = NUM_W'(cfg.dst_height) << (Q_W - 1);
                  quo_x_in = '0;
                  quo_y_in = '0;
                  cnt_in   = CNT_W'(Q_W - 1);
                  state_in = DIVIDE;
               end
            end
         end
         DIVIDE: begin
            rem_x_in = ge_x ? rem_x_ff - div_x_ff : rem_x_ff;
            rem_y_in = ge_y ? rem_y_ff - div_y_ff : rem_y_ff;
            quo_x_in = (quo_x_ff << 1) | Q_W'(ge_x);
            quo_y_in = (quo_y_ff << 1) | Q_W'(ge_y);
            div_x_in = div_x_ff >> 1;
            div_y_in = div_y_ff >> 1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = INDEX;
            end
         end
         INDEX: begin
            addr_in  = ADDR_W'(ADDR_W'(quo_y_ff) * ADDR_W'(cfg.src_width)) + ADDR_W'(quo_x_ff);
            state_in = FETCH;
         end
         FETCH: begin
            state_in = EMIT;
         end
         EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = oor_ff ? '0 : (rd_data_ff & cfg.pixel_mask);
               rsp_oor_in   = oor_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      area_ff      <= AREA_W'(cfg.src_width) * AREA_W'(cfg.src_height);
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      div_x_ff     <= div_x_in;
      div_y_ff     <= div_y_in;
      quo_x_ff     <= quo_x_in;
      quo_y_ff     <= quo_y_in;
      cnt_ff       <= cnt_in;
      oor_ff       <= oor_in;
      addr_ff      <= addr_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[wr_pos] <= q_item.pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store[addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_oor_ff;

endmodule

[sv/nearest_neighbor_image_scaler.sv]
`timescale 1ns / 1ps
// A load passes the command queue and is written to the frame store once the back
// end takes it; a read passes dispatch, the one-bit-per-cycle restoring divider,
// index, fetch and output, one out of range skips to output. The back end takes
// one load per cycle while idle; a read holds it until its result is emitted.
// Reset: synchronous, clears control state and load position, registers take
// their defaults; the frame store is not cleared.
// -----------------------------------------------------------------------------
// Nearest-neighbour image scaler
// Frame store with raster load and scaled nearest-neighbour read-out.
// -----------------------------------------------------------------------------
module nearest_neighbor_image_scaler import nns_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_in, dst_col, dst_row
   input  logic                  req_tuser,   // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pixel_out
   output logic                  rsp_tuser,   // out_of_range
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SRC_REG_W-1:0] src_width_ff;
   logic [SRC_REG_W-1:0] src_height_ff;
   logic [DST_W-1:0]     dst_width_ff;
   logic [DST_W-1:0]     dst_height_ff;
   logic [CH_REG_W-1:0]  channel_count_ff;
   reg_index_type        csr_index;
   logic                 csr_write;
   cfg_type              cfg;
   logic                 q_full, q_push, q_valid, q_pop;
   cmd_type              q_in_item, q_out_item;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= SRC_REG_W'(1);
         src_height_ff    <= SRC_REG_W'(1);
         dst_width_ff     <= DST_W'(1);
         dst_height_ff    <= DST_W'(1);
         channel_count_ff <= CH_REG_W'(3);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SRC_WIDTH:     src_width_ff     <= csr_pwdata[SRC_REG_W-1:0];
            REG_SRC_HEIGHT:    src_height_ff    <= csr_pwdata[SRC_REG_W-1:0];
            REG_DST_WIDTH:     dst_width_ff     <= csr_pwdata[DST_W-1:0];
            REG_DST_HEIGHT:    dst_height_ff    <= csr_pwdata[DST_W-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[CH_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SRC_WIDTH:     csr_prdata = CSR_DATA_W'(src_width_ff);
         REG_SRC_HEIGHT:    csr_prdata = CSR_DATA_W'(src_height_ff);
         REG_DST_WIDTH:     csr_prdata = CSR_DATA_W'(dst_width_ff);
         REG_DST_HEIGHT:    csr_prdata = CSR_DATA_W'(dst_height_ff);
         REG_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(channel_count_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.src_width  = clamp_src(src_width_ff);
      cfg.src_height = clamp_src(src_height_ff);
      cfg.dst_width  = clamp_dst(dst_width_ff);
      cfg.dst_height = clamp_dst(dst_height_ff);
      cfg.pixel_mask = pixel_mask(channel_count_ff);
   end

   nns_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   nns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_item  (q_out_item)
   );

   nns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_out_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[tb/tb_nearest_neighbor_image_scaler.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Nearest-neighbour image scaler testbench
// Loads source images through the request stream and reads scaled pixels back.
// A shadow frame store and register set predict every result. The tests cover
// register defaults, channel masking, size clamping, a stale load position and
// extreme coordinates, followed by randomised phases with bursty requests and
// a stalling result sink.
// -----------------------------------------------------------------------------
module tb_nearest_neighbor_image_scaler;
   import nns_pkg::*;

   localparam int IDLE_CYCLES = 20;
   localparam int PHASE_ITEMS = 56;
   localparam int PHASE_LOADS = 96;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             out_of_range;
   } scaled_pixel_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SLOW,
      SINK_PATTERN
   } sink_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // pixel_in, dst_col, dst_row
   logic                  req_tuser   = 1'b0; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // pixel_out
   logic                  rsp_tuser;          // out_of_range
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [SRC_REG_W-1:0] cfg_src_w    = SRC_REG_W'(1);
   logic [SRC_REG_W-1:0] cfg_src_h    = SRC_REG_W'(1);
   logic [DST_W-1:0]     cfg_dst_w    = DST_W'(1);
   logic [DST_W-1:0]     cfg_dst_h    = DST_W'(1);
   logic [CH_REG_W-1:0]  cfg_channels = CH_REG_W'(3);

   logic [PIX_W-1:0] shadow_frame   [STORE_DEPTH];
   bit               shadow_written [STORE_DEPTH];
   int unsigned      shadow_load_pos = 0;

   scaled_pixel_type pending_pixels[$];
   int               error_count = 0;
   int               burst_left  = 0;
   sink_mode_type    sink_mode   = SINK_OPEN;
   int               sink_tick   = 0;
   logic [7:0]       sink_pattern = 8'b1011_0010;

   nearest_neighbor_image_scaler uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_src(input logic [SRC_REG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int unsigned eff_dst(input logic [DST_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   // returns 0 when the coordinate lies outside the destination image
   function automatic bit map_to_source(input logic [COORD_W-1:0] col,
                                        input logic [COORD_W-1:0] row,
                                        output int unsigned idx);
      int unsigned sw, sh, dw, dh;
      longint unsigned sx, sy;
      sw = eff_src(cfg_src_w);
      sh = eff_src(cfg_src_h);
      dw = eff_dst(cfg_dst_w);
      dh = eff_dst(cfg_dst_h);
      idx = 0;
      if (col >= dw || row >= dh) return 0;
      sx = (longint'(col) * sw) / dw;
      sy = (longint'(row) * sh) / dh;
      idx = int'(sy * sw + sx);
      return 1;
   endfunction

   function automatic void record_transfer(input logic op, input logic [PIX_W-1:0] pix,
                                           input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
      int unsigned      area, pos, idx, n;
      logic [PIX_W-1:0] mask;
      scaled_pixel_type exp_px;
      if (op == OP_LOAD) begin
         area = eff_src(cfg_src_w) * eff_src(cfg_src_h);
         pos = shadow_load_pos;
         if (pos >= area) pos = 0;
         shadow_frame[pos]   = pix;
         shadow_written[pos] = 1'b1;
         pos++;
         if (pos >= area) pos = 0;
         shadow_load_pos = pos;
      end else begin
         if (map_to_source(col, row, idx)) begin
            n = int'(cfg_channels);
            if (n == 0) n = 1;
            if (n > MAX_CHANNELS) n = MAX_CHANNELS;
            if (n > 4) n = 4;
            mask = '0;
            for (int b = 0; b < int'(n); b++) mask[8*b +: 8] = 8'hFF;
            exp_px.pixel        = shadow_frame[idx] & mask;
            exp_px.out_of_range = 1'b0;
         end else begin
            exp_px.pixel        = '0;
            exp_px.out_of_range = 1'b1;
         end
         pending_pixels.push_back(exp_px);
      end
   endfunction

   task automatic send_item(input logic op, input logic [PIX_W-1:0] pix,
                            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {row, col, pix};
      do @(posedge clock); while (!req_tready);
      record_transfer(op, pix, col, row);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_load(input logic [PIX_W-1:0] pix);
      send_item(OP_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic send_read(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      send_item(OP_READ, PIX_W'($urandom), col, row);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type ridx, input int unsigned value);
      logic [CSR_DATA_W-1:0] wdata;
      wait_idle();
      wdata = $urandom;
      case (ridx)
         REG_SRC_WIDTH, REG_SRC_HEIGHT: begin
            wdata[SRC_REG_W-1:0] = SRC_REG_W'(value);
         end
         REG_DST_WIDTH, REG_DST_HEIGHT: begin
            wdata[DST_W-1:0] = DST_W'(value);
         end
         default: begin
            wdata[CH_REG_W-1:0] = CH_REG_W'(value);
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(ridx));
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (ridx)
         REG_SRC_WIDTH:  cfg_src_w    = wdata[SRC_REG_W-1:0];
         REG_SRC_HEIGHT: cfg_src_h    = wdata[SRC_REG_W-1:0];
         REG_DST_WIDTH:  cfg_dst_w    = wdata[DST_W-1:0];
         REG_DST_HEIGHT: cfg_dst_h    = wdata[DST_W-1:0];
         default:        cfg_channels = wdata[CH_REG_W-1:0];
      endcase
   endtask

   task automatic configure(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh,
                            input int unsigned ch);
      set_reg(REG_SRC_WIDTH, sw);
      set_reg(REG_SRC_HEIGHT, sh);
      set_reg(REG_DST_WIDTH, dw);
      set_reg(REG_DST_HEIGHT, dh);
      set_reg(REG_CHANNEL_COUNT, ch);
   endtask

   task automatic test_reset_defaults();
      send_load(32'hFFFF_FFFF);
      send_read(12'd0, 12'd0);
      send_read(12'd1, 12'd0);
      send_read(12'd0, 12'd4095);
      send_read(12'd4095, 12'd4095);
   endtask

   task automatic test_channel_masks();
      configure(2, 1, 2, 1, 4);
      send_load(32'h89AB_CDEF);
      send_load(32'h7654_3210);
      for (int ch = 0; ch < 8; ch++) begin
         set_reg(REG_CHANNEL_COUNT, ch);
         send_read(12'd1, 12'd0);
      end
   endtask

   task automatic test_size_clamps();
      configure(0, 300, 0, 8191, 4);
      repeat (3) send_load($urandom);
      send_read(12'd0, 12'd0);
      send_read(12'd0, 12'd32);
      send_read(12'd0, 12'd64);
      send_read(12'd1, 12'd0);
   endtask

   task automatic test_stale_load_position();
      configure(4, 4, 4, 4, 4);
      repeat (10) send_load($urandom);
      // shrink below the load position so the next load restarts at 0
      configure(2, 2, 2, 2, 4);
      send_load(32'hC3A5_5A3C);
      send_read(12'd0, 12'd0);
      send_read(12'd1, 12'd1);
   endtask

   task automatic test_extreme_coordinates();
      set_reg(REG_DST_WIDTH, 4096);
      set_reg(REG_DST_HEIGHT, 4096);
      send_read(12'd4095, 12'd4095);
      send_read(12'd0, 12'd0);
      send_read(12'd4095, 12'd0);
      send_read(12'd0, 12'd4095);
   endtask

   task automatic random_item();
      logic [COORD_W-1:0] col, row;
      int unsigned idx, lim_col, lim_row;
      bit found;
      if ($urandom_range(0, 9) < 2) begin
         send_load($urandom);
      end else begin
         lim_col = eff_dst(cfg_dst_w) > 4096 ? 4095 : eff_dst(cfg_dst_w) - 1;
         lim_row = eff_dst(cfg_dst_h) > 4096 ? 4095 : eff_dst(cfg_dst_h) - 1;
         found = 1'b0;
         for (int k = 0; k < 16 && !found; k++) begin
            if (k == 0 && $urandom_range(0, 9) == 0) begin
               col = COORD_W'($urandom);
               row = COORD_W'($urandom);
            end else begin
               col = COORD_W'($urandom_range(0, lim_col >> (k / 2)));
               row = COORD_W'($urandom_range(0, lim_row >> k));
            end
            found = !map_to_source(col, row, idx) || shadow_written[idx];
         end
         if (found) send_read(col, row);
         else send_load($urandom);
      end
   endtask

   task automatic test_random_phases();
      int unsigned sw, sh, dw, dh, area;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               sw = 256; sh = 1; dw = 4096; dh = 3;
            end
            1: begin
               sw = 1; sh = 256; dw = 5; dh = 4096;
            end
            2: begin
               sw = 511; sh = 300; dw = 8191; dh = 0;
            end
            default: begin
               sw = $urandom_range(0, 16);
               sh = $urandom_range(0, 16);
               dw = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 48);
               dh = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 48);
            end
         endcase
         configure(sw, sh, dw, dh, $urandom_range(0, 7));
         area = eff_src(cfg_src_w) * eff_src(cfg_src_h);
         repeat (area > PHASE_LOADS ? PHASE_LOADS : area) send_load($urandom);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 4 && i == PHASE_ITEMS / 2) wait_idle();
            random_item();
         end
      end
   endtask

   always @(posedge clock) begin
      sink_tick <= sink_tick + 1;
      if (sink_tick % 300 == 0) sink_mode <= sink_mode_type'($urandom_range(0, 3));
      sink_pattern <= {sink_pattern[6:0], sink_pattern[7]};
      case (sink_mode)
         SINK_OPEN:    rsp_tready <= 1'b1;
         SINK_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SLOW:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= sink_pattern[0];
      endcase
   end

   always @(posedge clock) begin
      scaled_pixel_type exp_px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result pixel %h flag %b", $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_tdata !== exp_px.pixel) begin
               $display("%0t: pixel_out mismatch expected %h actual %h",
                        $time, exp_px.pixel, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== exp_px.out_of_range) begin
               $display("%0t: out_of_range mismatch expected %b actual %b",
                        $time, exp_px.out_of_range, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_channel_masks();
      test_size_clamps();
      test_stale_load_position();
      test_extreme_coordinates();
      test_random_phases();
      wait_idle();
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_pixels.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
